@@ hw/rtl/three_level_priority_queue_top_assert.svh @@
// assertion macros shared by the queue rtl
// each macro takes a label, clock, reset, antecedent, consequent and a message
`ifndef THREE_LEVEL_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TLPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define TLPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
// delayed implication
`define TLPQ_ASSERT_LATER3(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##3 (cons)) \
      else $error(msg);
`else
`define TLPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define TLPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`define TLPQ_ASSERT_LATER3(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ hw/rtl/tlpq_pkg.sv @@
// ----------------------------------------------------------------------------
// tlpq_pkg
// types and codes shared by the priority queue controller, datapath and top
// ----------------------------------------------------------------------------
`default_nettype none

package tlpq_pkg;

   localparam int COUNT_W = 5;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam logic [1:0] CLASS_HIGH   = 2'd0;
   localparam logic [1:0] CLASS_MEDIUM = 2'd1;
   localparam logic [1:0] CLASS_LOW    = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] id;
      logic [1:0]  priority_req;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [15:0]        out_id;
      logic [1:0]         out_priority;
      logic [COUNT_W-1:0] high_count;
      logic [COUNT_W-1:0] medium_count;
      logic [COUNT_W-1:0] low_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic look;
      logic apply;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_busy;
   } stat_type;

endpackage

`default_nettype wire

@@ hw/rtl/tlpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// tlpq_ctrl
// sequencer: capture a request, compare all slots, then apply the update
// ----------------------------------------------------------------------------
`default_nettype none

module tlpq_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire tlpq_pkg::stat_type stat,
   output tlpq_pkg::cmd_type       cmd
);
   import tlpq_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      LOOK,
      APPLY
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) state_in = LOOK;
         end
         LOOK: begin
            state_in = APPLY;
         end
         APPLY: begin
            if (!stat.rsp_busy) state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready   = (state_ff == IDLE);
   assign cmd.capture = req_valid && (state_ff == IDLE);
   assign cmd.look    = (state_ff == LOOK);
   assign cmd.apply   = (state_ff == APPLY) && !stat.rsp_busy;

endmodule

`default_nettype wire

@@ hw/rtl/tlpq_dp.sv @@
// ----------------------------------------------------------------------------
// tlpq_dp
// ordered slot store with parallel compare, shift update and response register
// ----------------------------------------------------------------------------
`default_nettype none
`include "three_level_priority_queue_top_assert.svh"

module tlpq_dp #(
   parameter int CAPACITY = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tlpq_pkg::cmd_type cmd,
   input  wire tlpq_pkg::req_type req_data,
   output tlpq_pkg::stat_type     stat,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tlpq_pkg::rsp_type      rsp_data
);
   import tlpq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // captured request
   logic [1:0]  op_ff;
   logic [15:0] id_ff;
   logic [1:0]  cls_ff;

   // slot store, slot 0 is the head
   logic [15:0] slot_id_ff [CAPACITY];
   logic [1:0]  slot_cls_ff [CAPACITY];
   logic [15:0] slot_id_in [CAPACITY];
   logic [1:0]  slot_cls_in [CAPACITY];

   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [CNT_W-1:0] high_ff, high_in;
   logic [CNT_W-1:0] med_ff, med_in;
   logic [CNT_W-1:0] low_ff, low_in;

   // registered compare vectors
   logic [CAPACITY-1:0] le_ff;
   logic [CAPACITY-1:0] mvec_ff;
   logic [CAPACITY-1:0] le_in;
   logic [CAPACITY-1:0] mvec_in;

   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   logic                is_empty, is_full;
   logic [CAPACITY-1:0] lowmask, onehot, take;
   logic [15:0]         rid;
   logic [1:0]          rcls;

   assign is_empty = (occ_ff == '0);
   assign is_full  = (occ_ff == CNT_W'(CAPACITY));

   // parallel compare of every slot
   always_comb begin
      for (int k = 0; k < CAPACITY; k++) begin
         le_in[k]   = (CNT_W'(k) < occ_ff) && (slot_cls_ff[k] <= cls_ff);
         mvec_in[k] = (CNT_W'(k) < occ_ff) && (slot_id_ff[k] == id_ff);
      end
      if (op_ff == OP_POP) mvec_in = CAPACITY'(1);
   end

   // first match: bits from the head through it, and its one-hot position
   assign lowmask = mvec_ff ^ (mvec_ff - CAPACITY'(1));
   assign onehot  = mvec_ff & lowmask;
   assign take    = ~lowmask | onehot;

   always_comb begin
      rid  = '0;
      rcls = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         rid  = rid  | ({16{onehot[k]}} & slot_id_ff[k]);
         rcls = rcls | ({2{onehot[k]}} & slot_cls_ff[k]);
      end
   end

   always_comb begin
      for (int k = 0; k < CAPACITY; k++) begin
         slot_id_in[k]  = slot_id_ff[k];
         slot_cls_in[k] = slot_cls_ff[k];
      end
      occ_in  = occ_ff;
      high_in = high_ff;
      med_in  = med_ff;
      low_in  = low_ff;
      rsp_in.status       = ST_OK;
      rsp_in.out_id       = '0;
      rsp_in.out_priority = '0;

      case (op_ff)
         OP_INSERT: begin
            if (is_full) begin
               rsp_in.status = ST_FULL;
            end else begin
               for (int k = 0; k < CAPACITY; k++) begin
                  if (!le_ff[k]) begin
                     if (k == 0) begin
                        slot_id_in[k]  = id_ff;
                        slot_cls_in[k] = cls_ff;
                     end else if (le_ff[(k == 0) ? 0 : k - 1]) begin
                        slot_id_in[k]  = id_ff;
                        slot_cls_in[k] = cls_ff;
                     end else begin
                        slot_id_in[k]  = slot_id_ff[(k == 0) ? 0 : k - 1];
                        slot_cls_in[k] = slot_cls_ff[(k == 0) ? 0 : k - 1];
                     end
                  end
               end
               occ_in = occ_ff + CNT_W'(1);
               case (cls_ff)
                  CLASS_HIGH:   high_in = high_ff + CNT_W'(1);
                  CLASS_MEDIUM: med_in  = med_ff + CNT_W'(1);
                  default:      low_in  = low_ff + CNT_W'(1);
               endcase
            end
         end
         OP_POP, OP_REMOVE: begin
            if (is_empty) begin
               rsp_in.status = ST_EMPTY;
            end else if (mvec_ff == '0) begin
               rsp_in.status = ST_NOT_FOUND;
            end else begin
               // close the gap toward the head
               for (int k = 0; k < CAPACITY - 1; k++) begin
                  if (take[k]) begin
                     slot_id_in[k]  = slot_id_ff[k + 1];
                     slot_cls_in[k] = slot_cls_ff[k + 1];
                  end
               end
               rsp_in.out_id       = rid;
               rsp_in.out_priority = rcls;
               occ_in = occ_ff - CNT_W'(1);
               case (rcls)
                  CLASS_HIGH:   high_in = high_ff - CNT_W'(1);
                  CLASS_MEDIUM: med_in  = med_ff - CNT_W'(1);
                  default:      low_in  = low_ff - CNT_W'(1);
               endcase
            end
         end
         default: begin
         end
      endcase

      rsp_in.high_count   = COUNT_W'(high_in);
      rsp_in.medium_count = COUNT_W'(med_in);
      rsp_in.low_count    = COUNT_W'(low_in);
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_data.op;
         id_ff  <= req_data.id;
         cls_ff <= (req_data.priority_req > CLASS_LOW) ? CLASS_LOW : req_data.priority_req;
      end
      if (cmd.look) begin
         le_ff   <= le_in;
         mvec_ff <= mvec_in;
      end
      if (cmd.apply) begin
         for (int k = 0; k < CAPACITY; k++) begin
            slot_id_ff[k]  <= slot_id_in[k];
            slot_cls_ff[k] <= slot_cls_in[k];
         end
         rsp_ff <= rsp_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         high_ff      <= '0;
         med_ff       <= '0;
         low_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.apply) begin
            occ_ff  <= occ_in;
            high_ff <= high_in;
            med_ff  <= med_in;
            low_ff  <= low_in;
         end
         if (cmd.apply) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign stat.rsp_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

   `TLPQ_ASSERT_NOW(a_occ_sum, clock, reset, 1'b1,
      ({2'b00, occ_ff} == {2'b00, high_ff} + {2'b00, med_ff} + {2'b00, low_ff}),
      "occupancy differs from class counts")
   `TLPQ_ASSERT_NOW(a_occ_max, clock, reset, 1'b1, (occ_ff <= CNT_W'(CAPACITY)),
      "occupancy above capacity")
   `TLPQ_ASSERT_NEXT(a_insert_grow, clock, reset,
      (cmd.apply && (op_ff == OP_INSERT) && !is_full),
      (occ_ff == $past(occ_ff) + CNT_W'(1)), "insert did not grow occupancy")

endmodule

`default_nettype wire

@@ hw/rtl/three_level_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// three_level_priority_queue_top
// ordered queue of ids in three classes with insert, pop and remove by id
// ----------------------------------------------------------------------------
// each request transaction (insert, pop head, remove by id) yields exactly one
// response transaction with a status, the entry taken out and the class counts.
// the request is captured in the request registers when it is accepted; the
// compare step then registers a parallel compare of every slot of the
// shift-register store, and the update step shifts the store and loads the
// response register. one request is in flight at a time; a new one is accepted
// while the previous response still waits in the output register, and only its
// update step stalls until that response is taken. the store needs no clearing
// after reset. class code 3 is stored as low, op code 3 changes nothing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "three_level_priority_queue_top_assert.svh"

module three_level_priority_queue_top #(
   parameter int CAPACITY = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire tlpq_pkg::req_type req_data,
   // response channel
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tlpq_pkg::rsp_type      rsp_data
);
   import tlpq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer: idle, compare, update
   tlpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // slot store, counters and response register
   tlpq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // only one transaction in flight
   `TLPQ_ASSERT_NEXT(a_one_in_flight, clock, reset, (req_valid && req_ready),
      !req_ready, "second request accepted while busy")
   // with the output free at acceptance, the update step does not stall and the response is seen valid
   `TLPQ_ASSERT_LATER3(a_rsp_latency, clock, reset,
      (req_valid && req_ready && !rsp_valid), rsp_valid, "response late")
   // refused or failed operations carry no entry
   `TLPQ_ASSERT_NOW(a_no_entry_on_fail, clock, reset,
      (rsp_valid && (rsp_data.status != ST_OK)),
      ((rsp_data.out_id == 16'd0) && (rsp_data.out_priority == 2'd0)),
      "entry reported on failed operation")

endmodule

`default_nettype wire
